// ----- hw/rtl/fmsa_pkg.sv -----
// Package for the filtered market share aggregator.
// Holds widths, constants, controller state codes and the control/status structs.
// No dependencies.
`timescale 1ns / 1ps

package fmsa_pkg;

  localparam int NATION_COUNT = 25;
  localparam int MASK_NATIONS = 25;
  localparam int CUST_LIMIT   = (NATION_COUNT < MASK_NATIONS) ? NATION_COUNT : MASK_NATIONS;

  localparam int SUM_W   = 64;
  localparam int VOL_W   = 31;
  localparam int PROD_W  = 52;
  localparam int NUM_W   = 84;
  localparam int SHARE_W = 20;
  localparam int DIV_STEPS = SHARE_W;
  localparam int CNT_W   = 5;

  localparam logic [13:0]        YEAR_LO   = 14'd1995;
  localparam logic [13:0]        YEAR_HI   = 14'd1996;
  localparam logic [10:0]        RES_YEAR0 = 11'd1995;
  localparam logic [7:0]         NO_NATION = 8'hFF;
  localparam logic [6:0]         DISC_MAX  = 7'd100;
  localparam logic [SHARE_W-1:0] MILLION   = 20'd1000000;

  localparam logic [1:0] REG_PART_TYPE = 2'd0;
  localparam logic [1:0] REG_REGION    = 2'd1;
  localparam logic [1:0] REG_NATION    = 2'd2;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_FLUSH = 9'b000000010,
    ST_PICK  = 9'b000000100,
    ST_SEL   = 9'b000001000,
    ST_MULLO = 9'b000010000,
    ST_MULHI = 9'b000100000,
    ST_DINIT = 9'b001000000,
    ST_DIV   = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_e;

  typedef struct packed {
    logic accept;
    logic sel;
    logic mul_lo;
    logic mul_hi;
    logic div_init;
    logic div_step;
    logic rnd;
    logic clear;
    logic yr;
  } cmd_t;

  typedef struct packed {
    logic [1:0] tot_nz;
    logic       div_last;
  } sts_t;

endpackage

// ----- hw/rtl/fmsa_ctrl.sv -----
// Controller for the filtered market share aggregator.
// Sequences row intake, the end-of-run share computation and result delivery.
// Depends on fmsa_pkg.
`timescale 1ns / 1ps

module fmsa_ctrl (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  logic         in_last_i,
  input  logic         out_ready_i,
  input  fmsa_pkg::sts_t sts_i,
  output fmsa_pkg::cmd_t cmd_o,
  output logic         in_ready_o,
  output logic         out_valid_o
);
  import fmsa_pkg::*;

  state_e state_q, state_d;
  logic   yr_q, yr_d;
  logic   acc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign acc         = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    yr_d    = yr_q;
    cmd_o   = '0;
    cmd_o.accept = acc;
    cmd_o.yr     = yr_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && in_last_i) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        // last row's add lands at the end of this cycle
        yr_d    = 1'b0;
        state_d = ST_PICK;
      end
      ST_PICK: begin
        if (sts_i.tot_nz[yr_q]) begin
          state_d = ST_SEL;
        end else if (!yr_q) begin
          yr_d = 1'b1;
        end else begin
          cmd_o.clear = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_SEL: begin
        cmd_o.sel = 1'b1;
        state_d   = ST_MULLO;
      end
      ST_MULLO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MULHI;
      end
      ST_MULHI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_DINIT;
      end
      ST_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          cmd_o.rnd = 1'b1;
          state_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (!yr_q) begin
            yr_d    = 1'b1;
            state_d = ST_PICK;
          end else begin
            cmd_o.clear = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      yr_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      yr_q    <= yr_d;
    end
  end

endmodule

// ----- hw/rtl/fmsa_datapath.sv -----
// Datapath for the filtered market share aggregator.
// Config registers, row filter, volume accumulators, multiplier and share divider.
// Depends on fmsa_pkg.
`timescale 1ns / 1ps

module fmsa_datapath (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  fmsa_pkg::cmd_t cmd_i,
  output fmsa_pkg::sts_t sts_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [24:0]  cfg_wdata_i,
  input  logic [7:0]   part_type_i,
  input  logic [13:0]  order_year_i,
  input  logic [7:0]   cust_nation_i,
  input  logic [7:0]   supp_nation_i,
  input  logic [23:0]  price_cents_i,
  input  logic [6:0]   discount_pct_i,
  output logic [10:0]  result_year_o,
  output logic [19:0]  share_millionths_o,
  output logic         last_result_o
);
  import fmsa_pkg::*;

  logic [7:0]  tgt_part_q;
  logic [24:0] region_q;
  logic [7:0]  tgt_nat_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_part_q <= '0;
      region_q   <= '0;
      tgt_nat_q  <= NO_NATION;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PART_TYPE: tgt_part_q <= cfg_wdata_i[7:0];
        REG_REGION:    region_q   <= cfg_wdata_i;
        REG_NATION:    tgt_nat_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // row filter and volume
  logic             cust_ok, ok, yi, nat_hit;
  logic [6:0]       disc, mult;
  logic [VOL_W-1:0] vol;

  always_comb begin
    cust_ok = (cust_nation_i < 8'(CUST_LIMIT)) && region_q[cust_nation_i[4:0]];
    ok      = (part_type_i == tgt_part_q) &&
              ((order_year_i == YEAR_LO) || (order_year_i == YEAR_HI)) &&
              cust_ok && (supp_nation_i != NO_NATION);
    yi      = (order_year_i == YEAR_HI);
    nat_hit = (tgt_nat_q < 8'(NATION_COUNT)) && (supp_nation_i == tgt_nat_q);
    disc    = (discount_pct_i > DISC_MAX) ? DISC_MAX : discount_pct_i;
    mult    = DISC_MAX - disc;
    vol     = VOL_W'(price_cents_i) * VOL_W'(mult);
  end

  logic             acc_vld_q, acc_yi_q, acc_nat_q;
  logic [VOL_W-1:0] acc_vol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= 1'b0;
    end else begin
      acc_vld_q <= cmd_i.accept & ok;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      acc_yi_q  <= yi;
      acc_nat_q <= nat_hit;
      acc_vol_q <= vol;
    end
  end

  // saturating accumulators, index 0 is 1995
  logic [SUM_W-1:0] tot_q [2];
  logic [SUM_W-1:0] nat_q [2];
  logic [SUM_W:0]   tot_sum, nat_sum;

  assign tot_sum = {1'b0, tot_q[acc_yi_q]} + (SUM_W+1)'(acc_vol_q);
  assign nat_sum = {1'b0, nat_q[acc_yi_q]} + (SUM_W+1)'(acc_vol_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_q[0] <= '0;
      tot_q[1] <= '0;
      nat_q[0] <= '0;
      nat_q[1] <= '0;
    end else if (cmd_i.clear) begin
      tot_q[0] <= '0;
      tot_q[1] <= '0;
      nat_q[0] <= '0;
      nat_q[1] <= '0;
    end else if (acc_vld_q) begin
      tot_q[acc_yi_q] <= tot_sum[SUM_W] ? '1 : tot_sum[SUM_W-1:0];
      if (acc_nat_q) begin
        nat_q[acc_yi_q] <= nat_sum[SUM_W] ? '1 : nat_sum[SUM_W-1:0];
      end
    end
  end

  assign sts_o.tot_nz = {(tot_q[1] != '0), (tot_q[0] != '0)};

  // share: num * 1e6 in two partial products, then restoring division
  logic [SUM_W-1:0]   num_q, den_q, rem_q;
  logic [PROD_W-1:0]  plo_q, phi_q;
  logic [SHARE_W-1:0] nq_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [NUM_W-1:0]   prod;
  logic [SUM_W:0]     shifted, twice;
  logic               qbit;
  logic [SHARE_W-1:0] q_fin;
  logic [SHARE_W:0]   q_rnd;
  logic [SUM_W-1:0]   rem_nxt;

  assign prod    = NUM_W'(plo_q) + {phi_q, 32'b0};
  assign shifted = {rem_q, nq_q[SHARE_W-1]};
  assign qbit    = (shifted >= {1'b0, den_q});
  assign rem_nxt = qbit ? SUM_W'(shifted - {1'b0, den_q}) : shifted[SUM_W-1:0];
  assign q_fin   = {nq_q[SHARE_W-2:0], qbit};
  assign twice   = {rem_nxt, 1'b0};
  assign q_rnd   = {1'b0, q_fin} + (SHARE_W+1)'(twice >= {1'b0, den_q});
  assign sts_o.div_last = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sel) begin
      num_q <= (nat_q[cmd_i.yr] > tot_q[cmd_i.yr]) ? tot_q[cmd_i.yr] : nat_q[cmd_i.yr];
      den_q <= tot_q[cmd_i.yr];
    end
    if (cmd_i.mul_lo) begin
      plo_q <= PROD_W'(num_q[31:0]) * PROD_W'(MILLION);
    end
    if (cmd_i.mul_hi) begin
      phi_q <= PROD_W'(num_q[63:32]) * PROD_W'(MILLION);
    end
    if (cmd_i.div_init) begin
      rem_q <= prod[NUM_W-1:SHARE_W];
      nq_q  <= prod[SHARE_W-1:0];
      cnt_q <= CNT_W'(DIV_STEPS - 1);
    end else if (cmd_i.div_step) begin
      rem_q <= rem_nxt;
      nq_q  <= q_fin;
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.rnd) begin
      share_millionths_o <= (q_rnd > {1'b0, MILLION}) ? MILLION : q_rnd[SHARE_W-1:0];
      result_year_o      <= RES_YEAR0 + 11'(cmd_i.yr);
      last_result_o      <= cmd_i.yr | (tot_q[1] == '0);
    end
  end

endmodule

// ----- hw/rtl/filtered_market_share_aggregator.sv -----
// Top level of the filtered market share aggregator.
// Joins fmsa_ctrl and fmsa_datapath; depends on fmsa_pkg.
// Channel   | direction | handshake             | payload
// rows      | in        | in_valid_i/in_ready_o  | part_type .. last_row
// results   | out       | out_valid_o/out_ready_i| result_year, share, last_result
// config    | in        | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// Rows: one transaction per cycle while idle; each counted row's volume is
// added in the cycle after acceptance through a registered product stage.
// After a last row: a flush state, then per year with volume the steps select,
// two partial products, divider init and 20 divider steps with rounding
// before the result is offered; input is held off until all results have
// been taken and the sums cleared.
// Reset clears control state and sums; config resets to part 0, empty
// region, no target nation. A stalled result holds its payload.
`timescale 1ns / 1ps

module filtered_market_share_aggregator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [24:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  part_type_i,
  input  logic [13:0] order_year_i,
  input  logic [7:0]  cust_nation_i,
  input  logic [7:0]  supp_nation_i,
  input  logic [23:0] price_cents_i,
  input  logic [6:0]  discount_pct_i,
  input  logic        last_row_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [10:0] result_year_o,
  output logic [19:0] share_millionths_o,
  output logic        last_result_o
);
  import fmsa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller: row intake, share sequencing, result handshake
  fmsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (last_row_i),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o)
  );

  // datapath: filter, accumulate, multiply and divide
  fmsa_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .part_type_i        (part_type_i),
    .order_year_i       (order_year_i),
    .cust_nation_i      (cust_nation_i),
    .supp_nation_i      (supp_nation_i),
    .price_cents_i      (price_cents_i),
    .discount_pct_i     (discount_pct_i),
    .result_year_o      (result_year_o),
    .share_millionths_o (share_millionths_o),
    .last_result_o      (last_result_o)
  );

`ifndef ASSERT_OFF
  // a result is never offered while rows are being taken
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("result offered while input ready");

  // a last row stops intake in the following cycle
  a_last_stops_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_row_i) |=> !in_ready_o)
    else $error("input still ready after last row");

  // share never exceeds one million
  a_share_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (share_millionths_o <= 20'd1000000))
    else $error("share out of range");

  // a non-final result taken is not followed directly by another
  a_gap_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_result_o) |=> !out_valid_o)
    else $error("back-to-back results");
`endif

endmodule

// ----- verif/fmsa_share_checker.sv -----
// Scoreboard for the filtered market share aggregator: watches the config
// port and both channels, predicts the share results and compares them.
// Depends on fmsa_pkg.
`timescale 1ns / 1ps

module fmsa_share_checker
  import fmsa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [24:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  part_type_i,
  input  logic [13:0] order_year_i,
  input  logic [7:0]  cust_nation_i,
  input  logic [7:0]  supp_nation_i,
  input  logic [23:0] price_cents_i,
  input  logic [6:0]  discount_pct_i,
  input  logic        last_row_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [10:0] result_year_i,
  input  logic [19:0] share_millionths_i,
  input  logic        last_result_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [10:0] year;
    logic [19:0] share;
    logic        last;
  } share_row_t;

  logic [7:0]  tgt_part   = 8'd0;
  logic [24:0] region_map = 25'd0;
  logic [7:0]  tgt_nation = NO_NATION;

  // index 0 is 1995, index 1 is 1996
  logic [63:0] nat_vol [0:1];
  logic [63:0] tot_vol [0:1];

  share_row_t expected_shares [$];

  function automatic logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

  // round(num * 1e6 / den), ties up, capped at one million
  function automatic logic [19:0] share_ppm(logic [63:0] num, logic [63:0] den);
    logic [127:0] scaled;
    logic [127:0] d;
    logic [127:0] q;
    logic [127:0] r;
    d      = {64'd0, den};
    scaled = {64'd0, num} * 128'd1000000;
    q      = scaled / d;
    r      = scaled % d;
    if (r >= d - r) q = q + 128'd1;
    if (q > {108'd0, MILLION}) q = {108'd0, MILLION};
    return q[19:0];
  endfunction

  task automatic accumulate_row();
    logic [63:0] vol;
    logic [6:0]  disc;
    logic [63:0] num;
    logic        counted;
    share_row_t  exp_row;
    int          yi;
    int          y;
    counted = (part_type_i == tgt_part) && (supp_nation_i != NO_NATION) &&
              (order_year_i == YEAR_LO || order_year_i == YEAR_HI);
    if (cust_nation_i >= CUST_LIMIT) counted = 1'b0;
    else if (!region_map[cust_nation_i[4:0]]) counted = 1'b0;
    if (counted) begin
      yi   = (order_year_i == YEAR_LO) ? 0 : 1;
      disc = (discount_pct_i > DISC_MAX) ? DISC_MAX : discount_pct_i;
      vol  = {40'd0, price_cents_i} * {57'd0, 7'(DISC_MAX - disc)};
      tot_vol[yi] = sum_sat(tot_vol[yi], vol);
      if (tgt_nation < NATION_COUNT && supp_nation_i == tgt_nation)
        nat_vol[yi] = sum_sat(nat_vol[yi], vol);
    end
    if (last_row_i) begin
      for (y = 0; y < 2; y++) begin
        if (tot_vol[y] != 64'd0) begin
          num           = (nat_vol[y] > tot_vol[y]) ? tot_vol[y] : nat_vol[y];
          exp_row.year  = RES_YEAR0 + y[10:0];
          exp_row.share = share_ppm(num, tot_vol[y]);
          exp_row.last  = (y == 1) || (tot_vol[1] == 64'd0);
          expected_shares = {expected_shares, exp_row};
        end
      end
      nat_vol[0] = 64'd0;
      nat_vol[1] = 64'd0;
      tot_vol[0] = 64'd0;
      tot_vol[1] = 64'd0;
    end
  endtask

  task automatic compare_share();
    share_row_t want;
    if (expected_shares.size() == 0) begin
      fail_count_o++;
      if (fail_count_o <= 10)
        $display("%0t: unexpected result year %0d share %0d last %0b", $realtime,
                 result_year_i, share_millionths_i, last_result_i);
    end else begin
      want = expected_shares.pop_front();
      if (want.year !== result_year_i || want.share !== share_millionths_i ||
          want.last !== last_result_i) begin
        fail_count_o++;
        if (fail_count_o <= 10)
          $display("%0t: mismatch exp year %0d share %0d last %0b, got %0d %0d %0b",
                   $realtime, want.year, want.share, want.last,
                   result_year_i, share_millionths_i, last_result_i);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_part   = 8'd0;
      region_map = 25'd0;
      tgt_nation = NO_NATION;
      nat_vol[0] = 64'd0;
      nat_vol[1] = 64'd0;
      tot_vol[0] = 64'd0;
      tot_vol[1] = 64'd0;
      expected_shares.delete();
      pending_o  = 0;
    end else begin
      // a row taken at this edge still sees the config from before it
      if (in_valid_i && in_ready_i) accumulate_row();
      if (out_valid_i && out_ready_i) compare_share();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PART_TYPE: tgt_part   = cfg_wdata_i[7:0];
          REG_REGION:    region_map = cfg_wdata_i;
          REG_NATION:    tgt_nation = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      pending_o = expected_shares.size();
    end
  end

endmodule

// ----- verif/filtered_market_share_aggregator_tb.sv -----
// Testbench top for the filtered market share aggregator: clock, reset,
// row stimulus, config writes, result back-pressure and the verdict.
// Depends on fmsa_pkg, fmsa_share_checker and the block's RTL.
`timescale 1ns / 1ps

module filtered_market_share_aggregator_tb;
  import fmsa_pkg::*;

  // After a last row the block runs a flush and the share steps for each year,
  // so SETTLE_CYCLES of idle is well clear of any work still in flight.
  localparam int  SETTLE_CYCLES = 80;
  localparam int  DRAIN_CYCLES  = 100;
  localparam int  LONG_HOLD     = 400;
  localparam int  ROW_TARGET    = 1850;
  localparam real TIMEOUT_NS    = 40_000_000.0;

  typedef struct packed {
    logic [7:0]  part;
    logic [13:0] year;
    logic [7:0]  cust;
    logic [7:0]  supp;
    logic [23:0] price;
    logic [6:0]  disc;
    logic        last;
  } row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_idx   = REG_PART_TYPE;
  logic [24:0] cfg_wdata = 25'd0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  part_type = 8'd0;
  logic [13:0] order_year = 14'd0;
  logic [7:0]  cust_nation = 8'd0;
  logic [7:0]  supp_nation = 8'd0;
  logic [23:0] price_cents = 24'd0;
  logic [6:0]  discount_pct = 7'd0;
  logic        last_row  = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [10:0] result_year;
  logic [19:0] share_millionths;
  logic        last_result;

  int fail_count;
  int pending;

  // stimulus-side copy of the config, only used to shape well-formed rows
  logic [7:0]  cur_part   = 8'd0;
  logic [24:0] cur_mask   = 25'd0;
  logic [7:0]  cur_nation = NO_NATION;

  int unsigned rows_sent = 0;
  bit          quiet     = 1'b0;  // no idling on either side
  bit          long_hold = 1'b0;  // asks the receiver for one long stall

  always #10 clk = ~clk;

  filtered_market_share_aggregator i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .part_type_i        (part_type),
    .order_year_i       (order_year),
    .cust_nation_i      (cust_nation),
    .supp_nation_i      (supp_nation),
    .price_cents_i      (price_cents),
    .discount_pct_i     (discount_pct),
    .last_row_i         (last_row),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .result_year_o      (result_year),
    .share_millionths_o (share_millionths),
    .last_result_o      (last_result)
  );

  fmsa_share_checker i_share_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .part_type_i        (part_type),
    .order_year_i       (order_year),
    .cust_nation_i      (cust_nation),
    .supp_nation_i      (supp_nation),
    .price_cents_i      (price_cents),
    .discount_pct_i     (discount_pct),
    .last_row_i         (last_row),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .result_year_i      (result_year),
    .share_millionths_i (share_millionths),
    .last_result_i      (last_result),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  // Idle length: mostly none or short, now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Draws one row. A well-formed row passes every filter under the current
  // config (unless its customer misses a sparse region mask); noise spreads
  // over the full field ranges so every input bit toggles.
  function automatic row_t random_row(bit well_formed);
    row_t        r;
    int unsigned pick;
    int          tries;
    r.last  = 1'b0;
    r.price = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(0, 255)) : 24'($urandom);
    r.disc  = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(101, 127))
                                           : 7'($urandom_range(0, 100));
    if (well_formed) begin
      r.part = cur_part;
      r.year = $urandom_range(0, 1) ? YEAR_HI : YEAR_LO;
      r.cust = 8'($urandom_range(0, 24));
      for (tries = 0; tries < 60 && !cur_mask[r.cust]; tries++)
        r.cust = 8'($urandom_range(0, 24));
      r.supp = ($urandom_range(0, 1) && cur_nation != NO_NATION) ? cur_nation
                                                                : 8'($urandom_range(0, 254));
    end else begin
      pick   = $urandom_range(0, 9);
      r.part = (pick < 5) ? cur_part : 8'($urandom);
      pick   = $urandom_range(0, 9);
      r.year = (pick < 4) ? 14'($urandom_range(0, 16383)) :
               (pick < 7) ? 14'($urandom_range(1994, 1997)) :
               ($urandom_range(0, 1) ? YEAR_HI : YEAR_LO);
      r.cust = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 24));
      r.supp = ($urandom_range(0, 4) == 0) ? NO_NATION : 8'($urandom);
    end
    return r;
  endfunction

  // Offers one row and returns at the edge where the transaction is taken.
  task automatic send_row(row_t r);
    int unsigned gap;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    part_type    <= r.part;
    order_year   <= r.year;
    cust_nation  <= r.cust;
    supp_nation  <= r.supp;
    price_cents  <= r.price;
    discount_pct <= r.disc;
    last_row     <= r.last;
    do @(posedge clk); while (!in_ready);
    rows_sent++;
  endtask

  // Sender stops and waits for every outstanding result, then lets the
  // block's own latency run out so a config write finds it idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only ever called from idle (straight after reset or settle()).
  task automatic set_config(logic [7:0] part, logic [24:0] mask, logic [7:0] nation);
    cur_part   = part;
    cur_mask   = mask;
    cur_nation = nation;
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_PART_TYPE;
    cfg_wdata <= {17'd0, part};
    @(posedge clk);
    cfg_idx   <= REG_REGION;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_idx   <= REG_NATION;
    cfg_wdata <= {17'd0, nation};
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Receiver stalls for a long stretch while the sender keeps pushing short
  // runs, each closed by a last row: results back up and the input stalls.
  task automatic pressure_burst();
    row_t r;
    int   g;
    int   k;
    long_hold = 1'b1;
    for (g = 0; g < 8; g++) begin
      for (k = 0; k < 3; k++) begin
        r      = random_row(1'b1);
        r.last = (k == 2);
        send_row(r);
      end
    end
    settle();
  endtask

  // Result side: ready high by default, random stalls, plus the long hold
  // which is counted down here in cycles.
  initial begin
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        hold      = LONG_HOLD;
        long_hold = 1'b0;
      end
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 99) < 30) hold = idle_gap();
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL filtered_market_share_aggregator");
    $finish;
  end

  initial begin
    row_t        r;
    int unsigned phase_no;
    int unsigned n_rows;
    int unsigned noise_pct;
    int unsigned pick;
    int unsigned i;
    logic [7:0]  part;
    logic [24:0] mask;
    logic [7:0]  nation;

    phase_no = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed part ---
    // reset config: empty region, so nothing counts and the last row is silent
    send_row({8'd0, YEAR_LO, 8'd0, 8'd0, 24'd1000, 7'd0, 1'b1});
    settle();

    set_config(8'hFF, 25'h1FF_FFFF, 8'd24);
    send_row({8'hFF, YEAR_LO, 8'd24, 8'd24, 24'hFF_FFFF, 7'd0, 1'b0});   // max price
    send_row({8'hFF, YEAR_LO, 8'd0, 8'd3, 24'd123456, 7'd10, 1'b0});
    send_row({8'hFF, YEAR_HI, 8'd5, 8'd24, 24'd1000, 7'd100, 1'b0});     // zero volume
    send_row({8'hFF, YEAR_HI, 8'd7, 8'd24, 24'd5000, 7'd127, 1'b0});     // clamped discount
    send_row({8'hFF, YEAR_HI, 8'd7, 8'd24, 24'd777, 7'd50, 1'b0});
    send_row({8'hFF, YEAR_HI, 8'd9, 8'd1, 24'd2000, 7'd0, 1'b0});
    send_row({8'hFF, 14'd1994, 8'd1, 8'd24, 24'd9999, 7'd0, 1'b0});      // other years
    send_row({8'hFF, 14'd1997, 8'd1, 8'd24, 24'd9999, 7'd0, 1'b0});
    send_row({8'hFF, 14'd0, 8'd1, 8'd24, 24'd9999, 7'd0, 1'b0});
    send_row({8'hFF, 14'h3FFF, 8'd1, 8'd24, 24'd9999, 7'd0, 1'b0});
    send_row({8'hFF, YEAR_LO, 8'd25, 8'd24, 24'd9999, 7'd0, 1'b0});      // bad customer
    send_row({8'hFF, YEAR_LO, 8'hFF, 8'd24, 24'd9999, 7'd0, 1'b0});
    send_row({8'hFF, YEAR_LO, 8'd2, NO_NATION, 24'd9999, 7'd0, 1'b0});   // unknown supplier
    send_row({8'hFE, YEAR_LO, 8'd2, 8'd24, 24'd9999, 7'd0, 1'b0});       // wrong part
    send_row({8'h00, YEAR_LO, 8'd2, 8'd24, 24'd9999, 7'd0, 1'b0});
    send_row({8'hFF, YEAR_LO, 8'd3, 8'd24, 24'd100, 7'd0, 1'b1});        // both years
    send_row({8'hFF, YEAR_LO, 8'd3, 8'd24, 24'd0, 7'd0, 1'b1});          // counted, no volume
    settle();

    // target nation out of range; only nation 0 in region, only 1996 volume
    set_config(8'h00, 25'h000_0001, 8'd25);
    send_row({8'h00, YEAR_HI, 8'd0, 8'd25, 24'd500, 7'd20, 1'b0});
    send_row({8'h00, YEAR_HI, 8'd1, 8'd25, 24'd500, 7'd20, 1'b1});
    settle();

    // exact half-millionth: 1 / 2000000 must round up
    set_config(8'h3C, 25'h100_0000, 8'd0);
    send_row({8'h3C, YEAR_LO, 8'd24, 8'd0, 24'd1, 7'd99, 1'b0});
    send_row({8'h3C, YEAR_LO, 8'd24, 8'd7, 24'd1999999, 7'd99, 1'b1});
    settle();

    // no target nation: both years report zero share
    set_config(8'h3C, 25'h1FF_FFFF, NO_NATION);
    send_row({8'h3C, YEAR_LO, 8'd10, 8'd0, 24'd100, 7'd0, 1'b0});
    send_row({8'h3C, YEAR_HI, 8'd10, 8'd254, 24'd100, 7'd0, 1'b1});
    settle();

    // --- random part: one config per phase, each phase closed by a last row ---
    while (rows_sent < ROW_TARGET) begin
      phase_no++;
      if (phase_no == 20 || phase_no == 60) begin
        set_config(8'h11, 25'h1FF_FFFF, 8'd7);
        pressure_burst();
        continue;
      end

      pick = $urandom_range(0, 9);
      part = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
      pick = $urandom_range(0, 19);
      mask = (pick < 3) ? 25'h1FF_FFFF :
             (pick == 3) ? 25'd0 :
             (pick < 6) ? (25'd1 << $urandom_range(0, 24)) : 25'($urandom);
      pick = $urandom_range(0, 19);
      nation = (pick < 10) ? 8'($urandom_range(0, 24)) :
               (pick < 12) ? NO_NATION :
               (pick < 14) ? 8'($urandom_range(25, 254)) :
               (pick < 17) ? 8'd0 : 8'd24;
      set_config(part, mask, nation);

      quiet     = ($urandom_range(0, 99) < 15);
      n_rows    = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 30);
      noise_pct = ($urandom_range(0, 3) == 0) ? 40 : 8;
      for (i = 0; i < n_rows; i++) begin
        r      = random_row($urandom_range(0, 99) >= noise_pct);
        // an occasional mid-phase last row reports and clears early
        r.last = (i == n_rows - 1) || ($urandom_range(0, 99) < 3);
        send_row(r);
      end
      settle();
      quiet = 1'b0;
    end

    // settle() already waited for every result and the block's latency
    repeat (DRAIN_CYCLES - SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS filtered_market_share_aggregator");
    end else begin
      $display("FAIL filtered_market_share_aggregator");
    end
    $finish;
  end

endmodule
